// ===== rtl/core/drc_pkg.sv =====
`timescale 1ns / 1ps

package drc_pkg;

   localparam int ADDR_W     = 32;
   localparam int DEPTH_W    = 8;
   localparam int NUM_BKP    = 16;
   localparam int FUNC_W     = 3;
   localparam int KIND_W     = 3;
   localparam int RSTATE_W   = 4;
   localparam int STATUS_W   = 3;

   localparam logic [DEPTH_W-1:0] MAX_DEPTH   = 8'd255;
   localparam logic [DEPTH_W-1:0] ENTRY_DEPTH = 8'd1;
   localparam logic [ADDR_W-1:0]  MEM_SIZE_RESET = 32'hFFFF_FFFF;

   typedef enum logic [FUNC_W-1:0] {
      FN_INIT   = 3'd0,
      FN_UPDATE = 3'd1,
      FN_RESUME = 3'd2,
      FN_ADD    = 3'd3,
      FN_DELETE = 3'd4,
      FN_QUERY  = 3'd5,
      FN_STOP   = 3'd6
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      UK_OK     = 3'd0,
      UK_CALL   = 3'd1,
      UK_RETURN = 3'd2,
      UK_ERROR  = 3'd3,
      UK_EXIT   = 3'd4
   } upd_kind_type;

   typedef enum logic [KIND_W-1:0] {
      RK_FINISH   = 3'd0,
      RK_CONTINUE = 3'd1,
      RK_STEP     = 3'd2,
      RK_OVER     = 3'd3,
      RK_OUT      = 3'd4
   } res_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_RANGE    = 3'd1,
      ST_DUP      = 3'd2,
      ST_NONE     = 3'd3,
      ST_FINISHED = 3'd4,
      ST_STOPPED  = 3'd5,
      ST_FULL     = 3'd6,
      ST_BAD      = 3'd7
   } status_type;

   // run mode, one-hot
   typedef enum logic [8:0] {
      MD_NOT_STARTED = 9'b0_0000_0001,
      MD_STOPPED     = 9'b0_0000_0010,
      MD_FINISH      = 9'b0_0000_0100,
      MD_CONTINUE    = 9'b0_0000_1000,
      MD_STEP        = 9'b0_0001_0000,
      MD_OVER        = 9'b0_0010_0000,
      MD_OUT         = 9'b0_0100_0000,
      MD_ERROR       = 9'b0_1000_0000,
      MD_EXIT        = 9'b1_0000_0000
   } mode_type;

   localparam logic [RSTATE_W-1:0] RS_NOT_STARTED = 4'd0;
   localparam logic [RSTATE_W-1:0] RS_STOPPED     = 4'd1;
   localparam logic [RSTATE_W-1:0] RS_FINISH      = 4'd2;
   localparam logic [RSTATE_W-1:0] RS_CONTINUE    = 4'd3;
   localparam logic [RSTATE_W-1:0] RS_STEP        = 4'd4;
   localparam logic [RSTATE_W-1:0] RS_OVER        = 4'd5;
   localparam logic [RSTATE_W-1:0] RS_OUT         = 4'd6;
   localparam logic [RSTATE_W-1:0] RS_ERROR       = 4'd7;
   localparam logic [RSTATE_W-1:0] RS_EXIT        = 4'd8;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [KIND_W-1:0] update_kind;
      logic [ADDR_W-1:0] address;
      logic [KIND_W-1:0] resume_kind;
   } item_type;

   typedef struct packed {
      logic [RSTATE_W-1:0] run_state;
      logic [ADDR_W-1:0]   exec_address;
      logic [DEPTH_W-1:0]  depth_now;
      logic                bkp_present;
      logic [STATUS_W-1:0] status;
   } result_type;

   typedef struct packed {
      logic              add;
      logic              del;
      logic [ADDR_W-1:0] address;
   } bkp_cmd_type;

   typedef struct packed {
      logic hit;
      logic full;
   } bkp_look_type;

   function automatic logic [RSTATE_W-1:0] mode_code(input mode_type mode);
      logic [RSTATE_W-1:0] code;
      unique case (mode)
         MD_NOT_STARTED: code = RS_NOT_STARTED;
         MD_STOPPED:     code = RS_STOPPED;
         MD_FINISH:      code = RS_FINISH;
         MD_CONTINUE:    code = RS_CONTINUE;
         MD_STEP:        code = RS_STEP;
         MD_OVER:        code = RS_OVER;
         MD_OUT:         code = RS_OUT;
         MD_ERROR:       code = RS_ERROR;
         MD_EXIT:        code = RS_EXIT;
         default:        code = RS_NOT_STARTED;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/core/drc_req_if.sv =====
`timescale 1ns / 1ps

interface drc_req_if;
   logic                        valid;
   logic                        ready;
   logic [drc_pkg::FUNC_W-1:0]  func;
   logic [drc_pkg::KIND_W-1:0]  update_kind;
   logic [drc_pkg::ADDR_W-1:0]  address;
   logic [drc_pkg::KIND_W-1:0]  resume_kind;

   modport source (output valid, output func, output update_kind, output address,
                   output resume_kind, input ready);
   modport sink   (input valid, input func, input update_kind, input address,
                   input resume_kind, output ready);
endinterface

// ===== rtl/core/drc_rsp_if.sv =====
`timescale 1ns / 1ps

interface drc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [drc_pkg::RSTATE_W-1:0]  run_state;
   logic [drc_pkg::ADDR_W-1:0]    exec_address;
   logic [drc_pkg::DEPTH_W-1:0]   depth_now;
   logic                          bkp_present;
   logic [drc_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output run_state, output exec_address,
                   output depth_now, output bkp_present, output status, input ready);
   modport sink   (input valid, input run_state, input exec_address,
                   input depth_now, input bkp_present, input status, output ready);
endinterface

// ===== rtl/core/drc_csr_if.sv =====
`timescale 1ns / 1ps

interface drc_csr_if;
   logic                        valid;
   logic                        ready;
   logic [drc_pkg::ADDR_W-1:0]  mem_limit;

   modport source (output valid, output mem_limit, input ready);
   modport sink   (input valid, input mem_limit, output ready);
endinterface

// ===== rtl/core/drc_bkp_table.sv =====
`timescale 1ns / 1ps

module drc_bkp_table (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [drc_pkg::ADDR_W-1:0]  look_address,
   input  drc_pkg::bkp_cmd_type        cmd,
   output drc_pkg::bkp_look_type       look
);

   logic [drc_pkg::NUM_BKP-1:0] valid_ff;
   logic [drc_pkg::NUM_BKP-1:0] valid_in;
   logic [drc_pkg::ADDR_W-1:0]  addr_ff [drc_pkg::NUM_BKP];
   logic [drc_pkg::NUM_BKP-1:0] match;
   logic [drc_pkg::NUM_BKP-1:0] free;
   logic [drc_pkg::NUM_BKP-1:0] add_sel;

   // compare every entry in parallel
   always_comb begin
      for (int i = 0; i < drc_pkg::NUM_BKP; i++) begin
         match[i] = valid_ff[i] && (addr_ff[i] == look_address);
      end
   end

   // lowest free entry as a one-hot mask
   assign free     = ~valid_ff;
   assign add_sel  = free & (~free + {{(drc_pkg::NUM_BKP-1){1'b0}}, 1'b1});
   assign look.hit  = |match;
   assign look.full = ~|free;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.add) begin
         valid_in = valid_ff | add_sel;
      end else if (cmd.del) begin
         valid_in = valid_ff & ~match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < drc_pkg::NUM_BKP; i++) begin
         if (cmd.add && add_sel[i]) begin
            addr_ff[i] <= cmd.address;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_dup_entries: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("breakpoint address held in more than one entry");

   a_add_fills_one: assert property (@(posedge clock) disable iff (reset)
      cmd.add |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("breakpoint add did not fill exactly one entry");
`endif

endmodule

// ===== rtl/core/drc_ctrl.sv =====
`timescale 1ns / 1ps

module drc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  drc_pkg::item_type           item,
   input  logic [drc_pkg::ADDR_W-1:0]  mem_limit,
   input  drc_pkg::bkp_look_type       look,
   output drc_pkg::bkp_cmd_type        bkp_cmd,
   output drc_pkg::result_type         result
);

   drc_pkg::mode_type              mode_ff, mode_in;
   logic [drc_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [drc_pkg::DEPTH_W-1:0]    depth_ff, depth_in;
   logic [drc_pkg::DEPTH_W-1:0]    saved_ff, saved_in;
   drc_pkg::status_type            status;
   logic                           present;
   logic                           add_req;
   logic                           del_req;
   logic                           running;
   logic                           finished;
   logic                           in_range;
   logic                           stop_now;

   assign running  = (mode_ff == drc_pkg::MD_FINISH) || (mode_ff == drc_pkg::MD_CONTINUE)
                     || (mode_ff == drc_pkg::MD_STEP) || (mode_ff == drc_pkg::MD_OVER)
                     || (mode_ff == drc_pkg::MD_OUT);
   assign finished = (mode_ff == drc_pkg::MD_ERROR) || (mode_ff == drc_pkg::MD_EXIT);
   assign in_range = item.address < mem_limit;

   always_comb begin
      mode_in  = mode_ff;
      addr_in  = addr_ff;
      depth_in = depth_ff;
      saved_in = saved_ff;
      status   = drc_pkg::ST_OK;
      present  = 1'b0;
      add_req  = 1'b0;
      del_req  = 1'b0;
      stop_now = 1'b0;
      unique case (item.func)
         drc_pkg::FN_INIT: begin
            if (mode_ff != drc_pkg::MD_NOT_STARTED) begin
               status = drc_pkg::ST_BAD;
            end else begin
               mode_in  = drc_pkg::MD_FINISH;
               addr_in  = item.address;
               depth_in = drc_pkg::ENTRY_DEPTH;
            end
         end
         drc_pkg::FN_UPDATE: begin
            if (!running) begin
               status = drc_pkg::ST_BAD;
            end else begin
               unique case (item.update_kind)
                  drc_pkg::UK_ERROR: mode_in = drc_pkg::MD_ERROR;
                  drc_pkg::UK_EXIT:  mode_in = drc_pkg::MD_EXIT;
                  drc_pkg::UK_OK, drc_pkg::UK_CALL, drc_pkg::UK_RETURN: begin
                     addr_in = item.address;
                     // saturate the depth, flag but keep the rest of the update
                     if (item.update_kind == drc_pkg::UK_CALL) begin
                        if (depth_ff >= drc_pkg::MAX_DEPTH) begin
                           status = drc_pkg::ST_BAD;
                        end else begin
                           depth_in = depth_ff + 8'd1;
                        end
                     end else if (item.update_kind == drc_pkg::UK_RETURN) begin
                        if (depth_ff == '0) begin
                           status = drc_pkg::ST_BAD;
                        end else begin
                           depth_in = depth_ff - 8'd1;
                        end
                     end
                     stop_now = (mode_ff != drc_pkg::MD_FINISH) && (
                        (mode_ff == drc_pkg::MD_STEP)
                        || ((mode_ff == drc_pkg::MD_OVER) && (saved_ff >= depth_in))
                        || ((mode_ff == drc_pkg::MD_OUT)
                            && (item.update_kind == drc_pkg::UK_RETURN))
                        || look.hit);
                     if (stop_now) begin
                        mode_in = drc_pkg::MD_STOPPED;
                     end
                  end
                  default: status = drc_pkg::ST_BAD;
               endcase
            end
         end
         drc_pkg::FN_RESUME: begin
            if (finished) begin
               status = drc_pkg::ST_FINISHED;
            end else if (mode_ff == drc_pkg::MD_NOT_STARTED) begin
               status = drc_pkg::ST_BAD;
            end else begin
               unique case (item.resume_kind)
                  drc_pkg::RK_FINISH:   mode_in = drc_pkg::MD_FINISH;
                  drc_pkg::RK_CONTINUE: mode_in = drc_pkg::MD_CONTINUE;
                  drc_pkg::RK_STEP:     mode_in = drc_pkg::MD_STEP;
                  drc_pkg::RK_OVER: begin
                     mode_in  = drc_pkg::MD_OVER;
                     saved_in = depth_ff;
                  end
                  drc_pkg::RK_OUT:      mode_in = drc_pkg::MD_OUT;
                  default:              status  = drc_pkg::ST_BAD;
               endcase
            end
         end
         drc_pkg::FN_ADD: begin
            if (!in_range) begin
               status = drc_pkg::ST_RANGE;
            end else if (look.hit) begin
               status = drc_pkg::ST_DUP;
            end else if (look.full) begin
               status = drc_pkg::ST_FULL;
            end else begin
               add_req = 1'b1;
            end
         end
         drc_pkg::FN_DELETE: begin
            if (!in_range) begin
               status = drc_pkg::ST_RANGE;
            end else if (!look.hit) begin
               status = drc_pkg::ST_NONE;
            end else begin
               del_req = 1'b1;
            end
         end
         drc_pkg::FN_QUERY: begin
            if (!in_range) begin
               status = drc_pkg::ST_RANGE;
            end else begin
               present = look.hit;
            end
         end
         drc_pkg::FN_STOP: begin
            if (mode_ff == drc_pkg::MD_NOT_STARTED) begin
               status = drc_pkg::ST_BAD;
            end else if (finished) begin
               status = drc_pkg::ST_FINISHED;
            end else if (mode_ff == drc_pkg::MD_STOPPED) begin
               status = drc_pkg::ST_STOPPED;
            end else begin
               mode_in = drc_pkg::MD_STOPPED;
            end
         end
         default: status = drc_pkg::ST_BAD;
      endcase
   end

   assign bkp_cmd.add     = go && add_req;
   assign bkp_cmd.del     = go && del_req;
   assign bkp_cmd.address = item.address;

   assign result.run_state    = drc_pkg::mode_code(mode_in);
   assign result.exec_address = addr_in;
   assign result.depth_now    = depth_in;
   assign result.bkp_present  = present;
   assign result.status       = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= drc_pkg::MD_NOT_STARTED;
         addr_ff  <= '0;
         depth_ff <= '0;
         saved_ff <= '0;
      end else if (go) begin
         mode_ff  <= mode_in;
         addr_ff  <= addr_in;
         depth_ff <= depth_in;
         saved_ff <= saved_in;
      end
   end

`ifndef SYNTHESIS
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      go && (status != drc_pkg::ST_OK) && (item.func != drc_pkg::FN_UPDATE)
      |=> $stable(mode_ff) && $stable(addr_ff) && $stable(depth_ff) && $stable(saved_ff))
      else $error("rejected item changed the run state");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= drc_pkg::MAX_DEPTH)
      else $error("call depth beyond its limit");

   a_step_stops: assert property (@(posedge clock) disable iff (reset)
      go && (mode_ff == drc_pkg::MD_STEP) && (item.func == drc_pkg::FN_UPDATE)
      && (item.update_kind == drc_pkg::UK_OK)
      |=> mode_ff == drc_pkg::MD_STOPPED)
      else $error("single step did not stop after one update");
`endif

endmodule

// ===== rtl/core/debug_run_control.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Payload
// req_chan  in         valid/ready    func, update_kind, address, resume_kind
// rsp_chan  out        valid/ready    run_state, exec_address, depth_now,
//                                     bkp_present, status
// csr_chan  in         valid/ready    mem_limit (always ready)
//
// One item a cycle sustained while rsp_chan.ready stays high; each result is registered
// once its item, held in the input register, can advance, by a single pass through the
// run-control decision and the parallel breakpoint compare.
// Reset (synchronous, active high) returns to not started, clears every breakpoint
// and restores mem_limit to all ones.
// A stalled result holds; one more item still enters, then req_chan.ready drops.

module debug_run_control (
   input  logic              clock,
   input  logic              reset,
   drc_req_if.sink           req_chan,
   drc_rsp_if.source         rsp_chan,
   drc_csr_if.sink           csr_chan
);

   logic                        in_valid_ff, in_valid_in;
   drc_pkg::item_type           in_item_ff;
   logic                        out_valid_ff, out_valid_in;
   drc_pkg::result_type         out_data_ff;
   logic [drc_pkg::ADDR_W-1:0]  mem_size_ff;
   logic                        accept;
   logic                        advance;
   logic                        go;
   drc_pkg::result_type         result;
   drc_pkg::bkp_cmd_type        bkp_cmd;
   drc_pkg::bkp_look_type       bkp_look;

   // advance the input register whenever the result register is free or being taken
   assign advance = !out_valid_ff || rsp_chan.ready;
   assign go      = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept  = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (go) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mem_size_ff  <= drc_pkg::MEM_SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            mem_size_ff <= csr_chan.mem_limit;
         end
      end
   end

   // payload registers: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.func        <= req_chan.func;
         in_item_ff.update_kind <= req_chan.update_kind;
         in_item_ff.address     <= req_chan.address;
         in_item_ff.resume_kind <= req_chan.resume_kind;
      end
      if (go) begin
         out_data_ff <= result;
      end
   end

   assign csr_chan.ready = 1'b1;

   drc_bkp_table u_bkp (
      .clock        (clock),
      .reset        (reset),
      .look_address (in_item_ff.address),
      .cmd          (bkp_cmd),
      .look         (bkp_look)
   );

   drc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .item        (in_item_ff),
      .mem_limit   (mem_size_ff),
      .look        (bkp_look),
      .bkp_cmd     (bkp_cmd),
      .result      (result)
   );

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.run_state    = out_data_ff.run_state;
   assign rsp_chan.exec_address = out_data_ff.exec_address;
   assign rsp_chan.depth_now    = out_data_ff.depth_now;
   assign rsp_chan.bkp_present  = out_data_ff.bkp_present;
   assign rsp_chan.status       = out_data_ff.status;

`ifndef SYNTHESIS
   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !go)
      else $error("result register overwritten while stalled");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !go |=> in_valid_ff && $stable(in_item_ff))
      else $error("pending item lost before it was processed");

   a_go_gives_result: assert property (@(posedge clock) disable iff (reset)
      go |=> out_valid_ff)
      else $error("processed item produced no result");
`endif

endmodule
